// ===== sv/deq_pkg.sv =====
package deq_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ICOUNT_W = 5;

	typedef logic [REQ_W-1:0]    req_type_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic signed [WORD_W-1:0] word_t;

	localparam req_type_t REQ_PUSH_BACK  = 2'd0;
	localparam req_type_t REQ_PUSH_FRONT = 2'd1;
	localparam req_type_t REQ_POP_BACK   = 2'd2;
	localparam req_type_t REQ_POP_FRONT  = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	// per-beat result bookkeeping handed from the pointer logic to the output stage
	typedef struct packed {
		logic                  pop_ok;
		logic                  is_empty;
		status_t               status;
		logic [ICOUNT_W-1:0]   item_count;
	} deq_meta_t;

endpackage

// ===== sv/deq_if.sv =====
interface deq_req_if
	import deq_pkg::*;
();
	logic      valid;
	logic      ready;
	req_type_t req_type;
	word_t     push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if
	import deq_pkg::*;
();
	logic                valid;
	logic                ready;
	word_t               pop_value;
	logic                is_empty;
	status_t             status;
	logic [ICOUNT_W-1:0] item_count;

	modport source (output valid, output pop_value, output is_empty, output status,
		output item_count, input ready);
	modport sink (input valid, input pop_value, input is_empty, input status,
		input item_count, output ready);
endinterface

// ===== sv/double_ended_queue_unit.sv =====
// Deque of signed 32-bit words in a DEPTH-entry ring memory.
// A result beat appears in the cycle after its request beat is taken.
// Throughput: one request per cycle unless the output stalls; pointers update
// at acceptance; the single memory port serves each request's one write or read.
// Reset: arst_n clears front pointer, fill count and output valid; the
// memory is not cleared, no entry is read before it is written.
module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          accept;
	logic          wr_en, rd_en;
	logic [AW-1:0] addr;
	deq_meta_t     meta;
	deq_meta_t     meta_s1;
	logic          out_valid_q;
	word_t         rd_data;

	// read data is only refreshed on a new beat, so it holds while the output stalls
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req.req_type),
		.wr_en    (wr_en),
		.rd_en    (rd_en),
		.addr     (addr),
		.meta     (meta)
	);

	deq_ring_mem #(.DEPTH(DEPTH)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.rd_en   (rd_en),
		.addr    (addr),
		.wr_data (req.push_value),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.pop_value  = meta_s1.pop_ok ? rd_data : '0;
	assign rsp.is_empty   = meta_s1.is_empty;
	assign rsp.status     = meta_s1.status;
	assign rsp.item_count = meta_s1.item_count;

endmodule

// ===== sv/deq_ring_mem.sv =====
module deq_ring_mem
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic          rd_en,
	input  logic [AW-1:0] addr,
	input  word_t         wr_data,
	output word_t         rd_data
);

	word_t mem [DEPTH];
	word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/deq_ctrl.sv =====
module deq_ctrl
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  req_type_t     req_type,
	output logic          wr_en,
	output logic          rd_en,
	output logic [AW-1:0] addr,
	output deq_meta_t     meta
);

	localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;

	logic          is_push, is_full, is_zero;
	logic [AW:0]   back_sum, tail_sum;
	logic [AW-1:0] back_slot, tail_slot, front_dec, front_inc;
	logic [AW-1:0] front_d;
	logic [CW-1:0] count_d;
	logic          ok;

	assign is_push = (req_type == REQ_PUSH_BACK) || (req_type == REQ_PUSH_FRONT);
	assign is_full = (count_q == CW'(DEPTH));
	assign is_zero = (count_q == '0);

	// slot just past the back word, and the back word itself, wrapped once
	assign back_sum  = (AW+1)'(front_q) + (AW+1)'(count_q);
	assign tail_sum  = (AW+1)'(front_q) + (AW+1)'(count_q) - (AW+1)'(1);
	assign back_slot = (back_sum >= DEPTH_X) ? AW'(back_sum - DEPTH_X) : AW'(back_sum);
	assign tail_slot = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
	assign front_dec = (front_q == '0) ? LAST : AW'(front_q - AW'(1));
	assign front_inc = (front_q == LAST) ? '0 : AW'(front_q + AW'(1));

	always_comb begin
		addr    = front_q;
		front_d = front_q;
		count_d = count_q;
		ok      = is_push ? !is_full : !is_zero;
		case (req_type)
			REQ_PUSH_BACK: begin
				addr = back_slot;
				if (ok) count_d = CW'(count_q + CW'(1));
			end
			REQ_PUSH_FRONT: begin
				addr = front_dec;
				if (ok) begin
					front_d = front_dec;
					count_d = CW'(count_q + CW'(1));
				end
			end
			REQ_POP_BACK: begin
				addr = tail_slot;
				if (ok) count_d = CW'(count_q - CW'(1));
			end
			REQ_POP_FRONT: begin
				addr = front_q;
				if (ok) begin
					front_d = front_inc;
					count_d = CW'(count_q - CW'(1));
				end
			end
			default: begin
				addr = front_q;
			end
		endcase
	end

	assign wr_en = accept && is_push && ok;
	assign rd_en = accept && !is_push && ok;

	always_comb begin
		meta.pop_ok     = !is_push && ok;
		meta.is_empty   = (count_d == '0);
		meta.item_count = ICOUNT_W'(count_d);
		if (ok)           meta.status = ST_OK;
		else if (is_push) meta.status = ST_OVERFLOW;
		else              meta.status = ST_UNDERFLOW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== sv/deq_checker.sv =====
module deq_checker
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input req_type_t           req_type,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input word_t               pop_value,
	input logic                is_empty,
	input status_t             status,
	input logic [ICOUNT_W-1:0] item_count
);

	localparam bit SMALL = (DEPTH < 32);

	// a push can never report underflow, and its beat turns up next cycle
	a_push_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready &&
			(req_type == REQ_PUSH_BACK || req_type == REQ_PUSH_FRONT))
		|=> (rsp_valid && status != ST_UNDERFLOW))
		else $error("push beat did not give a push result");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_UNDERFLOW) |-> (pop_value == '0 && is_empty))
		else $error("underflow beat with data or non-empty queue");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_OVERFLOW) |-> (pop_value == '0 && !is_empty))
		else $error("overflow beat with data or empty queue");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && SMALL) |-> (is_empty == (item_count == '0)))
		else $error("empty flag disagrees with item count");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pop_value) &&
			$stable(status) && $stable(item_count)))
		else $error("stalled result beat changed");

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_type   (req.req_type),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.pop_value  (rsp.pop_value),
	.is_empty   (rsp.is_empty),
	.status     (rsp.status),
	.item_count (rsp.item_count)
);
